// ===== hw/rtl/fpsa_pkg.sv =====
// Package of the free page stack allocator: sizes, codes, payload words and the memory request.
`timescale 1ns / 1ps

package fpsa_pkg;

  localparam int unsigned PAGE_BITS = 12;
  localparam int unsigned MAX_PAGES = 32768;
  localparam int unsigned ADDR_BITS = 32;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned COUNT_W   = 21;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 1;

  // Page number width, stack index width and stack pointer width.
  localparam int unsigned PN_W  = ADDR_BITS - PAGE_BITS;
  localparam int unsigned IDX_W = $clog2(MAX_PAGES);
  localparam int unsigned TOP_W = $clog2(MAX_PAGES + 1);
  // Page cursor of the fill walk; one bit above a rounded 32-bit address plus a page.
  localparam int unsigned PTR_W = ADDR_W + 2;

  localparam logic [63:0] ADDR_MASK = (64'd1 << ADDR_BITS) - 64'd1;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_INIT  = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC    = 3'd0,
    ST_FREED    = 3'd1,
    ST_OOM      = 3'd2,
    ST_BADFREE  = 3'd3,
    ST_INIT     = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_END = 1'b0,
    CFG_PHYS_TOP   = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_FILL,
    S_HOLD
  } state_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] address;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   page_address;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  free_count;
  } out_word_t;

  typedef struct packed {
    logic             en;
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [PN_W-1:0]  wdata;
  } mem_req_t;

endpackage

// ===== hw/rtl/fpsa_ram.sv =====
// Single-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module fpsa_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 32768
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/fpsa_ctrl.sv =====
// Stack controller: configuration, stack pointer, operation sequencer and output register.
`timescale 1ns / 1ps

module fpsa_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fpsa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fpsa_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  fpsa_pkg::in_word_t                  in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output fpsa_pkg::out_word_t                 out_word_o,
  output fpsa_pkg::mem_req_t                  mem_req_o,
  input  logic [fpsa_pkg::PN_W-1:0]           mem_rdata_i
);

  import fpsa_pkg::*;

  localparam logic [PTR_W-1:0] PG_SIZE = PTR_W'(64'd1 << PAGE_BITS);
  localparam logic [TOP_W-1:0] TOP_MAX = TOP_W'(MAX_PAGES);

  function automatic logic [PN_W-1:0] addr_to_pn(logic [PTR_W-1:0] a);
    logic [63:0] w;
    w = (64'(a) & ADDR_MASK) >> PAGE_BITS;
    return PN_W'(w);
  endfunction

  function automatic logic [ADDR_W-1:0] pn_to_addr(logic [PN_W-1:0] pn);
    logic [63:0] w;
    w = (64'(pn) << PAGE_BITS) & ADDR_MASK;
    return w[ADDR_W-1:0];
  endfunction

  state_e            state_q, state_d;
  logic [TOP_W-1:0]  top_q, top_d;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic [ADDR_W-1:0] kernel_end_q, phys_top_q;
  out_word_t         hold_q, hold_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_q, out_d;

  logic              accept;
  logic              res_valid;
  out_word_t         res;
  logic              out_free;
  logic              bad_free;
  logic [PTR_W-1:0]  ptr_next;
  logic [PTR_W-1:0]  start_page;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign bad_free = (in_word_i.address[PAGE_BITS-1:0] != '0) ||
                    (in_word_i.address < kernel_end_q) ||
                    (in_word_i.address >= phys_top_q);
  assign ptr_next   = ptr_q + PG_SIZE;
  assign start_page = (PTR_W'(kernel_end_q) + PG_SIZE - PTR_W'(1)) & ~(PG_SIZE - PTR_W'(1));

  always_comb begin
    state_d     = state_q;
    top_d       = top_q;
    ptr_d       = ptr_q;
    hold_d      = hold_q;
    res_valid   = 1'b0;
    res         = '0;
    mem_req_o   = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_word_i.action)
            ACT_ALLOC: begin
              if (top_q == '0) begin
                res_valid  = 1'b1;
                res.status = ST_OOM;
              end else begin
                top_d          = top_q - TOP_W'(1);
                mem_req_o.en   = 1'b1;
                mem_req_o.addr = top_d[IDX_W-1:0];
                state_d        = S_POP;
              end
            end
            ACT_FREE: begin
              res_valid = 1'b1;
              if (bad_free) begin
                res.status = ST_BADFREE;
              end else if (top_q == TOP_MAX) begin
                res.status = ST_OVERFLOW;
              end else begin
                mem_req_o.en    = 1'b1;
                mem_req_o.we    = 1'b1;
                mem_req_o.addr  = top_q[IDX_W-1:0];
                mem_req_o.wdata = addr_to_pn(PTR_W'(in_word_i.address));
                top_d           = top_q + TOP_W'(1);
                res.status      = ST_FREED;
              end
            end
            ACT_INIT: begin
              top_d   = '0;
              ptr_d   = start_page;
              state_d = S_FILL;
            end
            default: begin
              res_valid  = 1'b1;
              res.status = ST_BADFREE;
            end
          endcase
        end
      end
      S_POP: begin
        res_valid        = 1'b1;
        res.status       = ST_ALLOC;
        res.page_address = pn_to_addr(mem_rdata_i);
        state_d          = S_IDLE;
      end
      S_FILL: begin
        // One page is pushed per cycle until the region or the stack runs out.
        if (ptr_next <= PTR_W'(phys_top_q)) begin
          if (top_q == TOP_MAX) begin
            res_valid  = 1'b1;
            res.status = ST_OVERFLOW;
            state_d    = S_IDLE;
          end else begin
            mem_req_o.en    = 1'b1;
            mem_req_o.we    = 1'b1;
            mem_req_o.addr  = top_q[IDX_W-1:0];
            mem_req_o.wdata = addr_to_pn(ptr_q);
            top_d           = top_q + TOP_W'(1);
            ptr_d           = ptr_next;
          end
        end else begin
          res_valid  = 1'b1;
          res.status = ST_INIT;
          state_d    = S_IDLE;
        end
      end
      S_HOLD: begin
        res_valid = 1'b1;
        res       = hold_q;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (res_valid && state_q != S_HOLD) begin
      res.free_count = COUNT_W'(top_d);
    end

    // A finished word that cannot enter the output register waits in the hold slot.
    if (res_valid && !out_free) begin
      hold_d  = res;
      state_d = S_HOLD;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && out_free) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      top_q        <= '0;
      out_valid_q  <= 1'b0;
      kernel_end_q <= '0;
      phys_top_q   <= ADDR_W'(32'h0800_0000);
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_KERNEL_END: kernel_end_q <= cfg_wdata_i[ADDR_W-1:0];
          CFG_PHYS_TOP:   phys_top_q   <= cfg_wdata_i[ADDR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== hw/rtl/free_page_stack_allocator.sv =====
// Top level of the free page stack allocator: controller and page number stack memory.
//
//   Channel   Direction  Handshake             Word
//   in        input      in_valid_i/in_stall_o   action, address
//   out       output     out_valid_o/out_stall_i page_address, status, free_count
//   cfg       input      cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// Free, bad free, out of memory and unused actions form their result word in the cycle they are
// accepted; allocate goes on to S_POP, since the popped page number comes back from the
// stack memory in the cycle after its read. Initialize pushes the pages of the region,
// bounded by the stack depth, as the single memory write port pushes one page number a cycle.
// Reset empties the stack at once; the stack memory itself is never cleared.
// One finished word can wait in a hold slot while the output register is stalled.
`timescale 1ns / 1ps

module free_page_stack_allocator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fpsa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fpsa_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  fpsa_pkg::in_word_t                  in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output fpsa_pkg::out_word_t                 out_word_o
);

  import fpsa_pkg::*;

  mem_req_t        mem_req;
  logic [PN_W-1:0] mem_rdata;

  fpsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  fpsa_ram #(
    .WIDTH (PN_W),
    .DEPTH (MAX_PAGES)
  ) u_stack (
    .clk_i   (clk_i),
    .en_i    (mem_req.en),
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== hw/rtl/fpsa_chk.sv =====
// Port checker of the free page stack allocator and its bind to the top level.
`timescale 1ns / 1ps

module fpsa_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input fpsa_pkg::in_word_t           in_word_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input fpsa_pkg::out_word_t          out_word_o
);

  import fpsa_pkg::*;

  // A stalled output word stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  // Initialize walks the region over later cycles, so the input stalls right after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_word_i.action == ACT_INIT |=> in_stall_o)
    else $error("input not stalled during initialize");

  // Only an allocation carries a page address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status != ST_ALLOC |-> out_word_o.page_address == '0)
    else $error("page address on a non-allocation word");

  // The count never exceeds the stack depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.free_count <= COUNT_W'(MAX_PAGES))
    else $error("free count beyond stack depth");

endmodule

bind free_page_stack_allocator fpsa_chk u_fpsa_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
